// File: rtl/ring_queue_with_remove_by_id_core_assert.svh
// Assertion macros shared by the ring queue RTL.
// Each macro expects the including module to have ports named clock and reset.
`ifndef RING_QUEUE_WITH_REMOVE_BY_ID_CORE_ASSERT_SVH
`define RING_QUEUE_WITH_REMOVE_BY_ID_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RQRID_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define RQRID_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/rqrid_pkg.sv
// Shared types and constants for the ring queue with remove by id.
// No dependencies; every RTL module refers to this package by scoped names.
`timescale 1ns / 1ps

package rqrid_pkg;

   localparam int CAPACITY      = 16;
   localparam int ID_BITS       = 16;
   localparam int PAYLOAD_BITS  = 32;
   localparam int KIND_BITS     = 2;
   localparam int POS_BITS      = 4;
   localparam int STATUS_BITS   = 2;
   localparam int IDX_BITS      = $clog2(CAPACITY);
   localparam int CNT_BITS      = $clog2(CAPACITY + 1);
   localparam int CMP_BITS      = (CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS;
   localparam int CMDQ_DEPTH    = 2;
   localparam int CMDQ_PTR_BITS = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_OCC_BITS = $clog2(CMDQ_DEPTH + 1);

   typedef enum logic [KIND_BITS-1:0] {
      KIND_ENQUEUE = 2'd0,
      KIND_DEQUEUE = 2'd1,
      KIND_PEEK    = 2'd2,
      KIND_REMOVE  = 2'd3
   } cmd_kind_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      cmd_kind_type              kind;
      logic [ID_BITS-1:0]        id;
      logic [PAYLOAD_BITS-1:0]   payload;
      logic [POS_BITS-1:0]       pos;
   } cmd_type;

endpackage

// File: rtl/rqrid_front.sv
// Front end: takes request transactions, decodes the command kind and holds
// the decoded command in one register stage. Depends on rqrid_pkg.
`timescale 1ns / 1ps

module rqrid_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [rqrid_pkg::KIND_BITS-1:0]   req_kind,
   input  logic [rqrid_pkg::ID_BITS-1:0]     req_entry_id,
   input  logic [rqrid_pkg::PAYLOAD_BITS-1:0] req_entry_payload,
   input  logic [rqrid_pkg::POS_BITS-1:0]    req_peek_position,
   output logic                              push_valid,
   input  logic                              push_ready,
   output rqrid_pkg::cmd_type                push_cmd
);

   logic               stage_valid_ff;
   logic               stage_valid_in;
   rqrid_pkg::cmd_type stage_cmd_ff;
   rqrid_pkg::cmd_type stage_cmd_in;
   logic               req_fire;

   assign req_ready  = !stage_valid_ff || push_ready;
   assign req_fire   = req_valid && req_ready;
   assign push_valid = stage_valid_ff;
   assign push_cmd   = stage_cmd_ff;

   always_comb begin
      stage_cmd_in.kind    = rqrid_pkg::cmd_kind_type'(req_kind);
      stage_cmd_in.id      = req_entry_id;
      stage_cmd_in.payload = req_entry_payload;
      stage_cmd_in.pos     = req_peek_position;
      if (req_fire) begin
         stage_valid_in = 1'b1;
      end else if (push_ready) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_cmd_ff <= stage_cmd_in;
      end
   end

endmodule

// File: rtl/rqrid_cmd_queue.sv
// Short command queue between the front end and the execution back end.
// Depends on rqrid_pkg and the shared assertion header.
`timescale 1ns / 1ps
`include "ring_queue_with_remove_by_id_core_assert.svh"

module rqrid_cmd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  rqrid_pkg::cmd_type push_cmd,
   output logic               pop_valid,
   input  logic               pop_ready,
   output rqrid_pkg::cmd_type pop_cmd
);

   rqrid_pkg::cmd_type                      slot_ff [rqrid_pkg::CMDQ_DEPTH];
   logic [rqrid_pkg::CMDQ_PTR_BITS-1:0]     wr_ptr_ff;
   logic [rqrid_pkg::CMDQ_PTR_BITS-1:0]     wr_ptr_in;
   logic [rqrid_pkg::CMDQ_PTR_BITS-1:0]     rd_ptr_ff;
   logic [rqrid_pkg::CMDQ_PTR_BITS-1:0]     rd_ptr_in;
   logic [rqrid_pkg::CMDQ_OCC_BITS-1:0]     occ_ff;
   logic [rqrid_pkg::CMDQ_OCC_BITS-1:0]     occ_in;
   logic                                    push_fire;
   logic                                    pop_fire;

   localparam logic [rqrid_pkg::CMDQ_PTR_BITS-1:0] LAST_PTR =
      rqrid_pkg::CMDQ_PTR_BITS'(rqrid_pkg::CMDQ_DEPTH - 1);
   localparam logic [rqrid_pkg::CMDQ_OCC_BITS-1:0] FULL_OCC =
      rqrid_pkg::CMDQ_OCC_BITS'(rqrid_pkg::CMDQ_DEPTH);

   assign push_ready = (occ_ff != FULL_OCC);
   assign pop_valid  = (occ_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      occ_in    = occ_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         occ_in = occ_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         occ_in = occ_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         occ_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         occ_ff    <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `RQRID_ASSERT_NOW(a_cmdq_occ_bound, 1'b1, occ_ff <= FULL_OCC, "command queue overfilled")

endmodule

// File: rtl/rqrid_back.sv
// Back end: the row of queue cells (head at cell 0) that executes each command,
// plus the response register. Depends on rqrid_pkg and the assertion header.
`timescale 1ns / 1ps
`include "ring_queue_with_remove_by_id_core_assert.svh"

module rqrid_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                cmd_valid,
   output logic                                cmd_ready,
   input  rqrid_pkg::cmd_type                  cmd,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [rqrid_pkg::STATUS_BITS-1:0]   rsp_status,
   output logic [rqrid_pkg::ID_BITS-1:0]       rsp_out_id,
   output logic [rqrid_pkg::PAYLOAD_BITS-1:0]  rsp_out_payload,
   output logic [rqrid_pkg::CNT_BITS-1:0]      rsp_entry_count,
   output logic                                rsp_queue_empty
);

   localparam logic [rqrid_pkg::CNT_BITS-1:0] FULL_COUNT =
      rqrid_pkg::CNT_BITS'(rqrid_pkg::CAPACITY);

   logic [rqrid_pkg::ID_BITS-1:0]      cell_id_ff  [rqrid_pkg::CAPACITY];
   logic [rqrid_pkg::ID_BITS-1:0]      cell_id_in  [rqrid_pkg::CAPACITY];
   logic [rqrid_pkg::PAYLOAD_BITS-1:0] cell_pay_ff [rqrid_pkg::CAPACITY];
   logic [rqrid_pkg::PAYLOAD_BITS-1:0] cell_pay_in [rqrid_pkg::CAPACITY];
   logic [rqrid_pkg::CNT_BITS-1:0]     count_ff;
   logic [rqrid_pkg::CNT_BITS-1:0]     count_in;

   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   rqrid_pkg::status_type              rsp_status_ff;
   rqrid_pkg::status_type              rsp_status_in;
   logic [rqrid_pkg::ID_BITS-1:0]      rsp_id_ff;
   logic [rqrid_pkg::ID_BITS-1:0]      rsp_id_in;
   logic [rqrid_pkg::PAYLOAD_BITS-1:0] rsp_pay_ff;
   logic [rqrid_pkg::PAYLOAD_BITS-1:0] rsp_pay_in;
   logic [rqrid_pkg::CNT_BITS-1:0]     rsp_count_ff;

   logic [rqrid_pkg::CAPACITY-1:0]     match;
   logic [rqrid_pkg::CAPACITY-1:0]     hit;
   logic                               seen;
   logic                               full;
   logic                               found;
   logic                               cmd_fire;

   assign cmd_ready = !rsp_valid_ff || rsp_ready;
   assign cmd_fire  = cmd_valid && cmd_ready;
   assign full      = (count_ff == FULL_COUNT);
   assign found     = hit[rqrid_pkg::CAPACITY-1];

   // Each held cell compares its id; hit marks the first match and every cell
   // after it; on a remove, each of them but the last pulls from its successor.
   always_comb begin
      seen = 1'b0;
      for (int i = 0; i < rqrid_pkg::CAPACITY; i++) begin
         match[i] = (rqrid_pkg::CNT_BITS'(i) < count_ff) && (cell_id_ff[i] == cmd.id);
         seen     = seen | match[i];
         hit[i]   = seen;
      end
   end

   always_comb begin
      for (int i = 0; i < rqrid_pkg::CAPACITY; i++) begin
         cell_id_in[i]  = cell_id_ff[i];
         cell_pay_in[i] = cell_pay_ff[i];
      end
      count_in      = count_ff;
      rsp_status_in = rqrid_pkg::STATUS_OK;
      rsp_id_in     = '0;
      rsp_pay_in    = '0;
      unique case (cmd.kind)
         rqrid_pkg::KIND_ENQUEUE: begin
            if (full) begin
               rsp_status_in = rqrid_pkg::STATUS_FULL;
            end else begin
               for (int i = 0; i < rqrid_pkg::CAPACITY; i++) begin
                  if (rqrid_pkg::CNT_BITS'(i) == count_ff) begin
                     cell_id_in[i]  = cmd.id;
                     cell_pay_in[i] = cmd.payload;
                  end
               end
               count_in = count_ff + 1'b1;
            end
         end
         rqrid_pkg::KIND_DEQUEUE: begin
            if (count_ff == '0) begin
               rsp_status_in = rqrid_pkg::STATUS_EMPTY;
            end else begin
               rsp_id_in  = cell_id_ff[0];
               rsp_pay_in = cell_pay_ff[0];
               for (int i = 0; i < rqrid_pkg::CAPACITY - 1; i++) begin
                  cell_id_in[i]  = cell_id_ff[i+1];
                  cell_pay_in[i] = cell_pay_ff[i+1];
               end
               count_in = count_ff - 1'b1;
            end
         end
         rqrid_pkg::KIND_PEEK: begin
            if (rqrid_pkg::CMP_BITS'(cmd.pos) >= rqrid_pkg::CMP_BITS'(count_ff)) begin
               rsp_status_in = rqrid_pkg::STATUS_EMPTY;
            end else begin
               rsp_id_in  = cell_id_ff[rqrid_pkg::IDX_BITS'(cmd.pos)];
               rsp_pay_in = cell_pay_ff[rqrid_pkg::IDX_BITS'(cmd.pos)];
            end
         end
         rqrid_pkg::KIND_REMOVE: begin
            if (!found) begin
               rsp_status_in = rqrid_pkg::STATUS_NOT_FOUND;
            end else begin
               for (int i = 0; i < rqrid_pkg::CAPACITY - 1; i++) begin
                  if (hit[i]) begin
                     cell_id_in[i]  = cell_id_ff[i+1];
                     cell_pay_in[i] = cell_pay_ff[i+1];
                  end
               end
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (cmd_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd_fire) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_fire) begin
         for (int i = 0; i < rqrid_pkg::CAPACITY; i++) begin
            cell_id_ff[i]  <= cell_id_in[i];
            cell_pay_ff[i] <= cell_pay_in[i];
         end
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_pay_ff    <= rsp_pay_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_id      = rsp_id_ff;
   assign rsp_out_payload = rsp_pay_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_queue_empty = (rsp_count_ff == '0);

   `RQRID_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= FULL_COUNT, "entry count above capacity")
   `RQRID_ASSERT_NEXT(a_enqueue_grows, cmd_fire && (cmd.kind == rqrid_pkg::KIND_ENQUEUE) && !full, count_ff == $past(count_ff) + 1'b1, "enqueue did not add an entry")
   `RQRID_ASSERT_NEXT(a_remove_shrinks, cmd_fire && (cmd.kind == rqrid_pkg::KIND_REMOVE) && found, count_ff == $past(count_ff) - 1'b1, "remove did not drop an entry")

endmodule

// File: rtl/ring_queue_with_remove_by_id_core.sv
// Ring queue with remove by id: a 16-entry FIFO of (id, payload) entries.
// Request channel (req_*): valid/ready; each transaction carries a command
// kind (enqueue, dequeue, peek at position, remove first entry with an id),
// an id, a payload and a peek position.
// Response channel (rsp_*): valid/ready; exactly one response per request,
// in order, with status, returned id and payload (zero unless a dequeue or
// peek succeeds), the entry count after the command and an empty flag.
// A request passes through the front register and the command queue, then is
// executed into the response register, from which its response is valid.
// Throughput: one command per cycle while rsp_ready is high; every command,
// including remove by id, is executed by the back end's row of entry cells.
// Reset (synchronous, active high) empties the queue and drops any commands
// and responses in flight; entry contents are not cleared.
// When the receiver stalls, the response register holds its transaction, the
// two-entry command queue and the front register fill, and req_ready falls.
// Depends on rqrid_pkg, rqrid_front, rqrid_cmd_queue and rqrid_back.
`timescale 1ns / 1ps

module ring_queue_with_remove_by_id_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [rqrid_pkg::KIND_BITS-1:0]     req_kind,
   input  logic [rqrid_pkg::ID_BITS-1:0]       req_entry_id,
   input  logic [rqrid_pkg::PAYLOAD_BITS-1:0]  req_entry_payload,
   input  logic [rqrid_pkg::POS_BITS-1:0]      req_peek_position,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [rqrid_pkg::STATUS_BITS-1:0]   rsp_status,
   output logic [rqrid_pkg::ID_BITS-1:0]       rsp_out_id,
   output logic [rqrid_pkg::PAYLOAD_BITS-1:0]  rsp_out_payload,
   output logic [rqrid_pkg::CNT_BITS-1:0]      rsp_entry_count,
   output logic                                rsp_queue_empty
);

   logic               push_valid;
   logic               push_ready;
   rqrid_pkg::cmd_type push_cmd;
   logic               pop_valid;
   logic               pop_ready;
   rqrid_pkg::cmd_type pop_cmd;

   rqrid_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_entry_id      (req_entry_id),
      .req_entry_payload (req_entry_payload),
      .req_peek_position (req_peek_position),
      .push_valid        (push_valid),
      .push_ready        (push_ready),
      .push_cmd          (push_cmd)
   );

   rqrid_cmd_queue u_cmd_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   rqrid_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (pop_valid),
      .cmd_ready       (pop_ready),
      .cmd             (pop_cmd),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_out_id      (rsp_out_id),
      .rsp_out_payload (rsp_out_payload),
      .rsp_entry_count (rsp_entry_count),
      .rsp_queue_empty (rsp_queue_empty)
   );

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for ring_queue_with_remove_by_id_core: directed and random
// enqueue, dequeue, peek and remove-by-id commands, checked against an in-bench queue model.
// Depends on rqrid_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_top;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_PER_PHASE = 300;

   typedef struct {
      rqrid_pkg::status_type                 status;
      logic [rqrid_pkg::ID_BITS-1:0]         id;
      logic [rqrid_pkg::PAYLOAD_BITS-1:0]    payload;
      logic [rqrid_pkg::CNT_BITS-1:0]        count;
      logic                                  empty;
   } queue_result_type;

   // Mirrors the ring contents and keeps the responses still owed by the core.
   class queue_scoreboard_type;
      logic [rqrid_pkg::ID_BITS-1:0]      ids [rqrid_pkg::CAPACITY];
      logic [rqrid_pkg::PAYLOAD_BITS-1:0] payloads [rqrid_pkg::CAPACITY];
      logic [rqrid_pkg::IDX_BITS-1:0]     head;
      logic [rqrid_pkg::CNT_BITS-1:0]     held;
      queue_result_type                   pending [$];
      int unsigned                        error_count;

      function new();
         foreach (ids[k]) begin
            ids[k] = '0;
            payloads[k] = '0;
         end
         head = '0;
         held = '0;
         error_count = 0;
      endfunction

      function logic [rqrid_pkg::IDX_BITS-1:0] slot(int unsigned offset);
         return rqrid_pkg::IDX_BITS'((head + offset) % rqrid_pkg::CAPACITY);
      endfunction

      function logic [rqrid_pkg::ID_BITS-1:0] held_id(int unsigned offset);
         return ids[slot(offset)];
      endfunction

      function void note_command(rqrid_pkg::cmd_kind_type kind,
            logic [rqrid_pkg::ID_BITS-1:0] id,
            logic [rqrid_pkg::PAYLOAD_BITS-1:0] payload,
            logic [rqrid_pkg::POS_BITS-1:0] pos);
         queue_result_type r;
         int unsigned match;
         bit found;
         r.status = rqrid_pkg::STATUS_OK;
         r.id = '0;
         r.payload = '0;
         found = 0;
         match = 0;
         case (kind)
            rqrid_pkg::KIND_ENQUEUE: begin
               if (held >= rqrid_pkg::CAPACITY) begin
                  r.status = rqrid_pkg::STATUS_FULL;
               end else begin
                  ids[slot(held)] = id;
                  payloads[slot(held)] = payload;
                  held++;
               end
            end
            rqrid_pkg::KIND_DEQUEUE: begin
               if (held == 0) begin
                  r.status = rqrid_pkg::STATUS_EMPTY;
               end else begin
                  r.id = ids[slot(0)];
                  r.payload = payloads[slot(0)];
                  head = slot(1);
                  held--;
               end
            end
            rqrid_pkg::KIND_PEEK: begin
               if (pos >= held) begin
                  r.status = rqrid_pkg::STATUS_EMPTY;
               end else begin
                  r.id = ids[slot(pos)];
                  r.payload = payloads[slot(pos)];
               end
            end
            default: begin
               for (int unsigned i = 0; i < held; i++) begin
                  if (!found && ids[slot(i)] == id) begin
                     found = 1;
                     match = i;
                  end
               end
               if (!found) begin
                  r.status = rqrid_pkg::STATUS_NOT_FOUND;
               end else begin
                  // Later entries move one place toward the head to close the gap.
                  for (int unsigned j = match; j + 1 < held; j++) begin
                     ids[slot(j)] = ids[slot(j + 1)];
                     payloads[slot(j)] = payloads[slot(j + 1)];
                  end
                  held--;
               end
            end
         endcase
         r.count = held;
         r.empty = (held == 0);
         pending.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
         end
      endfunction

      function void check_response(logic [rqrid_pkg::STATUS_BITS-1:0] status,
            logic [rqrid_pkg::ID_BITS-1:0] id,
            logic [rqrid_pkg::PAYLOAD_BITS-1:0] payload,
            logic [rqrid_pkg::CNT_BITS-1:0] count, logic empty);
         queue_result_type r;
         if (pending.size() == 0) begin
            $error("response transaction with no command outstanding");
            error_count++;
            return;
         end
         r = pending.pop_front();
         compare_field("status", 32'(r.status), 32'(status));
         compare_field("out_id", 32'(r.id), 32'(id));
         compare_field("out_payload", r.payload, payload);
         compare_field("entry_count", 32'(r.count), 32'(count));
         compare_field("queue_empty", 32'(r.empty), 32'(empty));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [rqrid_pkg::KIND_BITS-1:0] req_kind = '0;
   logic [rqrid_pkg::ID_BITS-1:0] req_entry_id = '0;
   logic [rqrid_pkg::PAYLOAD_BITS-1:0] req_entry_payload = '0;
   logic [rqrid_pkg::POS_BITS-1:0] req_peek_position = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [rqrid_pkg::STATUS_BITS-1:0] rsp_status;
   logic [rqrid_pkg::ID_BITS-1:0] rsp_out_id;
   logic [rqrid_pkg::PAYLOAD_BITS-1:0] rsp_out_payload;
   logic [rqrid_pkg::CNT_BITS-1:0] rsp_entry_count;
   logic rsp_queue_empty;

   int unsigned sender_idle_pct = 0;
   int unsigned receiver_idle_pct = 0;
   int unsigned cycle_count = 0;
   bit filling = 1'b1;

   queue_scoreboard_type queue_sb = new();

   ring_queue_with_remove_by_id_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_entry_id(req_entry_id),
      .req_entry_payload(req_entry_payload),
      .req_peek_position(req_peek_position),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_out_id(rsp_out_id),
      .rsp_out_payload(rsp_out_payload),
      .rsp_entry_count(rsp_entry_count),
      .rsp_queue_empty(rsp_queue_empty)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Response side: check each accepted transaction, then pick the next ready value.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            queue_sb.check_response(rsp_status, rsp_out_id, rsp_out_payload,
                                    rsp_entry_count, rsp_queue_empty);
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   task automatic send_command(rqrid_pkg::cmd_kind_type kind,
         logic [rqrid_pkg::ID_BITS-1:0] id,
         logic [rqrid_pkg::PAYLOAD_BITS-1:0] payload,
         logic [rqrid_pkg::POS_BITS-1:0] pos);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_entry_id <= id;
      req_entry_payload <= payload;
      req_peek_position <= pos;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      queue_sb.note_command(kind, id, payload, pos);
   endtask

   task automatic wait_for_responses();
      req_valid <= 1'b0;
      while (queue_sb.pending.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_directed();
      logic [rqrid_pkg::ID_BITS-1:0] id;
      send_command(rqrid_pkg::KIND_DEQUEUE, 16'h1111, 32'h0, 4'd0);
      send_command(rqrid_pkg::KIND_PEEK, 16'h0, 32'h0, 4'd0);
      send_command(rqrid_pkg::KIND_REMOVE, 16'h0, 32'h0, 4'd0);
      // Fill to capacity; two entries share an id so remove must take the first.
      for (int k = 0; k < rqrid_pkg::CAPACITY; k++) begin
         id = rqrid_pkg::ID_BITS'(16'h0100 + k);
         if (k == 0)
            send_command(rqrid_pkg::KIND_ENQUEUE, 16'h0000, 32'h0000_0000, 4'd0);
         else if (k == 1)
            send_command(rqrid_pkg::KIND_ENQUEUE, 16'hFFFF, 32'hFFFF_FFFF, 4'hF);
         else if (k == 5 || k == 9)
            send_command(rqrid_pkg::KIND_ENQUEUE, 16'h0055, $urandom, 4'd0);
         else
            send_command(rqrid_pkg::KIND_ENQUEUE, id, $urandom, 4'd0);
      end
      send_command(rqrid_pkg::KIND_ENQUEUE, 16'h1234, 32'hDEAD_BEEF, 4'd0);
      send_command(rqrid_pkg::KIND_PEEK, 16'h0, 32'h0, 4'hF);
      send_command(rqrid_pkg::KIND_REMOVE, 16'h0055, 32'h0, 4'd0);
      send_command(rqrid_pkg::KIND_REMOVE, 16'hBEEF, 32'h0, 4'd0);
      send_command(rqrid_pkg::KIND_PEEK, 16'h0, 32'h0, 4'hF);
      send_command(rqrid_pkg::KIND_DEQUEUE, 16'h0, 32'h0, 4'd0);
      send_command(rqrid_pkg::KIND_REMOVE, 16'hFFFF, 32'h0, 4'd0);
   endtask

   function automatic logic [rqrid_pkg::ID_BITS-1:0] pick_id();
      if ($urandom_range(99) < 55)
         return rqrid_pkg::ID_BITS'($urandom_range(7));
      return rqrid_pkg::ID_BITS'($urandom_range(16'hFFFF));
   endfunction

   task automatic run_random(int count);
      int unsigned r;
      rqrid_pkg::cmd_kind_type kind;
      logic [rqrid_pkg::ID_BITS-1:0] id;
      logic [rqrid_pkg::PAYLOAD_BITS-1:0] payload;
      logic [rqrid_pkg::POS_BITS-1:0] pos;
      for (int n = 0; n < count; n++) begin
         // Swing between filling and draining so both full and empty get exercised.
         if (queue_sb.held == rqrid_pkg::CAPACITY)
            filling = 1'b0;
         else if (queue_sb.held == 0)
            filling = 1'b1;
         else if ($urandom_range(39) == 0)
            filling = ~filling;
         r = $urandom_range(99);
         if (filling)
            kind = (r < 55) ? rqrid_pkg::KIND_ENQUEUE : (r < 70) ? rqrid_pkg::KIND_DEQUEUE :
                   (r < 85) ? rqrid_pkg::KIND_PEEK : rqrid_pkg::KIND_REMOVE;
         else
            kind = (r < 20) ? rqrid_pkg::KIND_ENQUEUE : (r < 50) ? rqrid_pkg::KIND_DEQUEUE :
                   (r < 70) ? rqrid_pkg::KIND_PEEK : rqrid_pkg::KIND_REMOVE;
         id = pick_id();
         if (kind == rqrid_pkg::KIND_REMOVE && queue_sb.held > 0 && $urandom_range(99) < 70)
            id = queue_sb.held_id($urandom_range(queue_sb.held - 1));
         r = $urandom_range(9);
         payload = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
         pos = rqrid_pkg::POS_BITS'($urandom_range(15));
         if (kind == rqrid_pkg::KIND_PEEK && queue_sb.held > 0 && $urandom_range(99) < 70)
            pos = rqrid_pkg::POS_BITS'($urandom_range(queue_sb.held - 1));
         send_command(kind, id, payload, pos);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      sender_idle_pct = 25;
      receiver_idle_pct = 74;
      run_directed();
      run_random(RANDOM_PER_PHASE);
      wait_for_responses();
      sender_idle_pct = 74;
      receiver_idle_pct = 25;
      run_random(RANDOM_PER_PHASE);
      wait_for_responses();
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      run_random(RANDOM_PER_PHASE);
      wait_for_responses();
      repeat (8) @(posedge clock);
      if (queue_sb.error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
